// ===== src/assert_macros.svh =====
// assertion macros shared by the shading pipeline modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define PBS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbs assertion failed");
// condition implies consequence in the next cycle
`define PBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbs assertion failed");
`else
`define PBS_ASSERT_IMP(label, clk, rst, ante, cons)
`define PBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/pbs_pkg.sv =====
// types, constants and fixed-point helpers of the phong shading pipeline
package pbs_pkg;

  // field widths
  localparam int DIR_W         = 16;
  localparam int DIR_FRAC_BITS = 14;
  localparam int COLOR_BITS    = 16;
  localparam int EXP_BITS      = 8;
  localparam int KD_W          = COLOR_BITS + 1;

  // internal widths
  localparam int PROD_W = 2 * DIR_W;
  localparam int DOT_W  = PROD_W + 1;
  localparam int QDOT_W = DOT_W - DIR_FRAC_BITS;
  localparam int REFL_W = 2 * QDOT_W;
  localparam int SPEC_W = REFL_W + 2;
  localparam int FB     = 2 * DIR_FRAC_BITS;
  localparam int SH     = FB - COLOR_BITS;
  localparam int UNIT_W = COLOR_BITS + 1;
  localparam int SUM_W  = UNIT_W + 1;

  // pipeline depths
  localparam int GEOM_STAGES  = 4;
  localparam int BLEND_STAGES = 3;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KD_W;

  typedef logic signed [DIR_W-1:0]  dir_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic signed [QDOT_W-1:0] qdot_t;
  typedef logic signed [REFL_W-1:0] refl_t;
  typedef logic signed [SPEC_W-1:0] spec_raw_t;
  typedef logic [UNIT_W-1:0]        unit_t;
  typedef logic [SUM_W-1:0]         inten_t;
  typedef logic [COLOR_BITS-1:0]    color_t;
  typedef logic [EXP_BITS-1:0]      exp_t;
  typedef logic [KD_W-1:0]          kd_t;

  localparam unit_t     UNIT_ONE  = UNIT_W'(1) << COLOR_BITS;
  localparam dot_t      DOT_RND   = DOT_W'(1) << (DIR_FRAC_BITS - 1);
  localparam spec_raw_t SPEC_FULL = SPEC_W'(1) << FB;

  typedef struct packed {
    dir_t x;
    dir_t y;
    dir_t z;
  } vec3_t;

  // diffuse and specular terms, both in [0, one]
  typedef struct packed {
    unit_t diffuse;
    unit_t specular;
  } terms_t;

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
  } shade_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_RED      = 3'd0,
    CFG_COLOR_GREEN    = 3'd1,
    CFG_COLOR_BLUE     = 3'd2,
    CFG_DIFFUSE_WEIGHT = 3'd3,
    CFG_SHINE_EXPONENT = 3'd4
  } cfg_index_t;

  // q0.16 product with round half up; a factor of one passes the other through
  function automatic unit_t mulq(unit_t a, unit_t b);
    logic [2*COLOR_BITS-1:0] p;
    unit_t r;
    p = (2*COLOR_BITS)'(a[COLOR_BITS-1:0]) * (2*COLOR_BITS)'(b[COLOR_BITS-1:0])
        + (2*COLOR_BITS)'(UNIT_ONE >> 1);
    if (a >= UNIT_ONE) begin
      r = b;
    end else if (b >= UNIT_ONE) begin
      r = a;
    end else begin
      r = UNIT_W'(p >> COLOR_BITS);
    end
    return r;
  endfunction

  // clamp a double-fraction dot value to [0, one] and round to q0.16
  function automatic unit_t to_unit(spec_raw_t v);
    logic [FB:0]   u;
    logic [FB+1:0] t;
    unit_t r;
    u = v[FB:0];
    t = {1'b0, u} + (FB+2)'(1 << (SH - 1));
    if (v <= 0) begin
      r = '0;
    end else if (v > SPEC_FULL) begin
      r = UNIT_ONE;
    end else begin
      r = t[FB:SH];
    end
    return r;
  endfunction

endpackage

// ===== src/pbs_if.sv =====
// valid/ready channel interfaces for direction vectors and shaded colors
interface pbs_vec_if;
  logic          valid;
  logic          ready;
  pbs_pkg::dir_t in_dir_x;
  pbs_pkg::dir_t in_dir_y;
  pbs_pkg::dir_t in_dir_z;
  pbs_pkg::dir_t normal_x;
  pbs_pkg::dir_t normal_y;
  pbs_pkg::dir_t normal_z;
  pbs_pkg::dir_t out_dir_x;
  pbs_pkg::dir_t out_dir_y;
  pbs_pkg::dir_t out_dir_z;

  modport source (
    output valid, in_dir_x, in_dir_y, in_dir_z, normal_x, normal_y, normal_z,
    output out_dir_x, out_dir_y, out_dir_z,
    input  ready
  );
  modport sink (
    input  valid, in_dir_x, in_dir_y, in_dir_z, normal_x, normal_y, normal_z,
    input  out_dir_x, out_dir_y, out_dir_z,
    output ready
  );
endinterface

interface pbs_shade_if;
  logic            valid;
  logic            ready;
  pbs_pkg::color_t shade_red;
  pbs_pkg::color_t shade_green;
  pbs_pkg::color_t shade_blue;

  modport source (output valid, shade_red, shade_green, shade_blue, input ready);
  modport sink (input valid, shade_red, shade_green, shade_blue, output ready);
endinterface

// ===== src/pbs_geom.sv =====
// geometry stages: dot products, reflection, clamped diffuse and specular terms
`include "assert_macros.svh"

module pbs_geom (
  input  logic            clk,
  input  logic            rst,
  input  logic            feed_valid,
  output logic            feed_ready,
  input  pbs_pkg::vec3_t  inc,
  input  pbs_pkg::vec3_t  nrm,
  input  pbs_pkg::vec3_t  outg,
  output logic            res_valid,
  input  logic            res_ready,
  output pbs_pkg::terms_t res_terms
);

  logic [pbs_pkg::GEOM_STAGES-1:0] v;
  logic [pbs_pkg::GEOM_STAGES:0]   rdy;

  pbs_pkg::dir_t ia [3];
  pbs_pkg::dir_t na [3];
  pbs_pkg::dir_t oa [3];

  // stage 0: products
  pbs_pkg::prod_t p_io [3];
  pbs_pkg::prod_t p_in [3];
  pbs_pkg::prod_t p_no [3];
  // stage 1: dot sums
  pbs_pkg::dot_t dio, din, dno;
  // stage 2: rounded reflection product and diffuse term
  pbs_pkg::dot_t  dio2;
  pbs_pkg::refl_t refl;
  pbs_pkg::unit_t diff;

  pbs_pkg::dot_t      rin, rno;
  pbs_pkg::qdot_t     dinq, dnoq;
  pbs_pkg::spec_raw_t spec;

  // stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    rdy[pbs_pkg::GEOM_STAGES] = res_ready;
    for (int k = pbs_pkg::GEOM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign feed_ready = rdy[0];
  assign res_valid  = v[pbs_pkg::GEOM_STAGES-1];

  always_comb begin
    ia[0] = inc.x;  ia[1] = inc.y;  ia[2] = inc.z;
    na[0] = nrm.x;  na[1] = nrm.y;  na[2] = nrm.z;
    oa[0] = outg.x; oa[1] = outg.y; oa[2] = outg.z;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= feed_valid;
      end
      for (int k = 1; k < pbs_pkg::GEOM_STAGES; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // round i.n and n.o to q.14, half toward plus infinity
  always_comb begin
    rin  = din + pbs_pkg::DOT_RND;
    rno  = dno + pbs_pkg::DOT_RND;
    dinq = rin[pbs_pkg::DOT_W-1:pbs_pkg::DIR_FRAC_BITS];
    dnoq = rno[pbs_pkg::DOT_W-1:pbs_pkg::DIR_FRAC_BITS];
    spec = pbs_pkg::SPEC_W'(dio2) - (pbs_pkg::SPEC_W'(refl) <<< 1);
  end

  // stage 0: nine products
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int k = 0; k < 3; k++) begin
        p_io[k] <= ia[k] * oa[k];
        p_in[k] <= ia[k] * na[k];
        p_no[k] <= na[k] * oa[k];
      end
    end
  end

  // stage 1: dot products
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      dio <= pbs_pkg::DOT_W'(p_io[0]) + pbs_pkg::DOT_W'(p_io[1]) + pbs_pkg::DOT_W'(p_io[2]);
      din <= pbs_pkg::DOT_W'(p_in[0]) + pbs_pkg::DOT_W'(p_in[1]) + pbs_pkg::DOT_W'(p_in[2]);
      dno <= pbs_pkg::DOT_W'(p_no[0]) + pbs_pkg::DOT_W'(p_no[1]) + pbs_pkg::DOT_W'(p_no[2]);
    end
  end

  // stage 2: reflection product and diffuse clamp
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dio2 <= dio;
      refl <= pbs_pkg::REFL_W'(dinq) * pbs_pkg::REFL_W'(dnoq);
      diff <= pbs_pkg::to_unit(pbs_pkg::SPEC_W'(dno));
    end
  end

  // stage 3: r.o and specular clamp
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      res_terms.diffuse  <= diff;
      res_terms.specular <= pbs_pkg::to_unit(spec);
    end
  end

  `PBS_ASSERT_IMP(a_terms_in_unit, clk, rst, res_valid, (res_terms.diffuse <= pbs_pkg::UNIT_ONE) && (res_terms.specular <= pbs_pkg::UNIT_ONE))

endmodule

// ===== src/pbs_pow.sv =====
// specular power by square-and-multiply, one exponent bit per stage
`include "assert_macros.svh"

module pbs_pow (
  input  logic            clk,
  input  logic            rst,
  input  logic            feed_valid,
  output logic            feed_ready,
  input  pbs_pkg::terms_t feed_terms,
  input  pbs_pkg::exp_t   shine,
  output logic            res_valid,
  input  logic            res_ready,
  output pbs_pkg::terms_t res_terms
);

  logic [pbs_pkg::EXP_BITS-1:0] v;
  logic [pbs_pkg::EXP_BITS:0]   rdy;

  // per-stage accumulator, base and carried diffuse term
  pbs_pkg::unit_t acc  [pbs_pkg::EXP_BITS];
  pbs_pkg::unit_t base [pbs_pkg::EXP_BITS-1];
  pbs_pkg::unit_t dif  [pbs_pkg::EXP_BITS];

  pbs_pkg::unit_t src_acc  [pbs_pkg::EXP_BITS];
  pbs_pkg::unit_t src_base [pbs_pkg::EXP_BITS];
  pbs_pkg::unit_t src_dif  [pbs_pkg::EXP_BITS];

  // stage enables
  always_comb begin
    rdy[pbs_pkg::EXP_BITS] = res_ready;
    for (int k = pbs_pkg::EXP_BITS - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign feed_ready = rdy[0];
  assign res_valid  = v[pbs_pkg::EXP_BITS-1];

  // stage inputs: the first stage starts the accumulator at one
  always_comb begin
    src_acc[0]  = pbs_pkg::UNIT_ONE;
    src_base[0] = feed_terms.specular;
    src_dif[0]  = feed_terms.diffuse;
    for (int k = 1; k < pbs_pkg::EXP_BITS; k++) begin
      src_acc[k]  = acc[k-1];
      src_base[k] = base[k-1];
      src_dif[k]  = dif[k-1];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= feed_valid;
      end
      for (int k = 1; k < pbs_pkg::EXP_BITS; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // multiply by the base where the exponent bit is set, square the base
  always_ff @(posedge clk) begin
    for (int k = 0; k < pbs_pkg::EXP_BITS; k++) begin
      if (rdy[k]) begin
        acc[k] <= shine[k] ? pbs_pkg::mulq(src_acc[k], src_base[k]) : src_acc[k];
        dif[k] <= src_dif[k];
      end
    end
    for (int k = 0; k < pbs_pkg::EXP_BITS - 1; k++) begin
      if (rdy[k]) begin
        base[k] <= pbs_pkg::mulq(src_base[k], src_base[k]);
      end
    end
  end

  assign res_terms.diffuse  = dif[pbs_pkg::EXP_BITS-1];
  assign res_terms.specular = acc[pbs_pkg::EXP_BITS-1];

  `PBS_ASSERT_IMP(a_zero_exp_is_one, clk, rst, res_valid && (shine == '0), res_terms.specular == pbs_pkg::UNIT_ONE)
  `PBS_ASSERT_IMP(a_power_in_unit, clk, rst, res_valid, res_terms.specular <= pbs_pkg::UNIT_ONE)

endmodule

// ===== src/pbs_blend.sv =====
// diffuse/specular blend and per-channel color scaling
module pbs_blend (
  input  logic            clk,
  input  logic            rst,
  input  logic            feed_valid,
  output logic            feed_ready,
  input  pbs_pkg::terms_t feed_terms,
  input  pbs_pkg::kd_t    kd,
  input  pbs_pkg::color_t color_red,
  input  pbs_pkg::color_t color_green,
  input  pbs_pkg::color_t color_blue,
  output logic            res_valid,
  input  logic            res_ready,
  output pbs_pkg::shade_t res_shade
);

  logic [pbs_pkg::BLEND_STAGES-1:0] v;
  logic [pbs_pkg::BLEND_STAGES:0]   rdy;

  pbs_pkg::unit_t  kd_sat, kd_inv;
  pbs_pkg::unit_t  pd, ps;
  pbs_pkg::inten_t inten;

  // intensity times color, saturated to the color range
  function automatic pbs_pkg::color_t chan(pbs_pkg::inten_t i, pbs_pkg::color_t c);
    pbs_pkg::unit_t m;
    pbs_pkg::color_t r;
    if (i >= pbs_pkg::SUM_W'(pbs_pkg::UNIT_ONE)) begin
      m = {1'b0, c};
    end else begin
      m = pbs_pkg::mulq(i[pbs_pkg::UNIT_W-1:0], {1'b0, c});
    end
    r = m[pbs_pkg::COLOR_BITS] ? '1 : m[pbs_pkg::COLOR_BITS-1:0];
    return r;
  endfunction

  // stage enables
  always_comb begin
    rdy[pbs_pkg::BLEND_STAGES] = res_ready;
    for (int k = pbs_pkg::BLEND_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign feed_ready = rdy[0];
  assign res_valid  = v[pbs_pkg::BLEND_STAGES-1];

  // weight above one acts as one
  always_comb begin
    kd_sat = (kd > pbs_pkg::UNIT_ONE) ? pbs_pkg::UNIT_ONE : kd;
    kd_inv = pbs_pkg::UNIT_ONE - kd_sat;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= feed_valid;
      end
      for (int k = 1; k < pbs_pkg::BLEND_STAGES; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 0: weighted terms
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pd <= pbs_pkg::mulq(feed_terms.diffuse, kd_sat);
      ps <= pbs_pkg::mulq(feed_terms.specular, kd_inv);
    end
  end

  // stage 1: blended intensity
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      inten <= pbs_pkg::SUM_W'(pd) + pbs_pkg::SUM_W'(ps);
    end
  end

  // stage 2: color channels, this is the output register
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      res_shade.red   <= chan(inten, color_red);
      res_shade.green <= chan(inten, color_green);
      res_shade.blue  <= chan(inten, color_blue);
    end
  end

endmodule

// ===== src/phong_brdf_shade_top.sv =====
// Phong shading pipeline: takes incoming direction, normal and outgoing direction
// as Q2.14 vectors and returns one Q0.16 RGB shade per item. A new item is
// accepted every cycle unless a stalled output has filled the pipe; each item
// passes through 4 + EXP_BITS + 3 = 15 register stages, the last of which is
// the output register. The depth is set mostly by the eight square-and-multiply
// stages of the specular exponent. Every stage holds its own valid bit and loads
// whenever it is empty or its successor moves, so a stalled output fills the pipe
// before the input stops taking transactions. The color, diffuse weight and
// exponent registers are written through the cfg port and must only change while
// no transaction is in flight.
`include "assert_macros.svh"

module phong_brdf_shade_top (
  input  logic                             clk,
  input  logic                             rst,
  pbs_vec_if.sink                          vectors,
  pbs_shade_if.source                      shades,
  input  logic                             cfg_write,
  input  logic [pbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pbs_pkg::color_t color_red, color_green, color_blue;
  pbs_pkg::kd_t    diffuse_weight;
  pbs_pkg::exp_t   shine_exponent;

  pbs_pkg::vec3_t  inc, nrm, outg;
  pbs_pkg::terms_t geom_terms, pow_terms;
  pbs_pkg::shade_t shade;
  logic            geom_valid, geom_ready, pow_valid, pow_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      color_red      <= '1;
      color_green    <= '1;
      color_blue     <= '1;
      diffuse_weight <= pbs_pkg::KD_W'(pbs_pkg::UNIT_ONE >> 1);
      shine_exponent <= pbs_pkg::EXP_BITS'(10);
    end else if (cfg_write) begin
      case (cfg_index)
        pbs_pkg::CFG_COLOR_RED:      color_red      <= cfg_data[pbs_pkg::COLOR_BITS-1:0];
        pbs_pkg::CFG_COLOR_GREEN:    color_green    <= cfg_data[pbs_pkg::COLOR_BITS-1:0];
        pbs_pkg::CFG_COLOR_BLUE:     color_blue     <= cfg_data[pbs_pkg::COLOR_BITS-1:0];
        pbs_pkg::CFG_DIFFUSE_WEIGHT: diffuse_weight <= cfg_data[pbs_pkg::KD_W-1:0];
        pbs_pkg::CFG_SHINE_EXPONENT: shine_exponent <= cfg_data[pbs_pkg::EXP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input payload
  always_comb begin
    inc.x  = vectors.in_dir_x;  inc.y  = vectors.in_dir_y;  inc.z  = vectors.in_dir_z;
    nrm.x  = vectors.normal_x;  nrm.y  = vectors.normal_y;  nrm.z  = vectors.normal_z;
    outg.x = vectors.out_dir_x; outg.y = vectors.out_dir_y; outg.z = vectors.out_dir_z;
  end

  pbs_geom u_geom (
    .clk        (clk),
    .rst        (rst),
    .feed_valid (vectors.valid),
    .feed_ready (vectors.ready),
    .inc        (inc),
    .nrm        (nrm),
    .outg       (outg),
    .res_valid  (geom_valid),
    .res_ready  (geom_ready),
    .res_terms  (geom_terms)
  );

  pbs_pow u_pow (
    .clk        (clk),
    .rst        (rst),
    .feed_valid (geom_valid),
    .feed_ready (geom_ready),
    .feed_terms (geom_terms),
    .shine      (shine_exponent),
    .res_valid  (pow_valid),
    .res_ready  (pow_ready),
    .res_terms  (pow_terms)
  );

  pbs_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .feed_valid  (pow_valid),
    .feed_ready  (pow_ready),
    .feed_terms  (pow_terms),
    .kd          (diffuse_weight),
    .color_red   (color_red),
    .color_green (color_green),
    .color_blue  (color_blue),
    .res_valid   (shades.valid),
    .res_ready   (shades.ready),
    .res_shade   (shade)
  );

  // output payload
  assign shades.shade_red   = shade.red;
  assign shades.shade_green = shade.green;
  assign shades.shade_blue  = shade.blue;

  `PBS_ASSERT_IMP(a_shade_le_color, clk, rst, shades.valid, (shades.shade_red <= color_red) && (shades.shade_green <= color_green) && (shades.shade_blue <= color_blue))

endmodule
